FILE: sv/skt_pkg.sv
// shared types, codes and defaults for the sorted key table
// used by every module of the block but skt_ram; depends on nothing

package skt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int POS_W        = 5;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_SET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } skt_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    entry_count;
  } skt_res_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROBE,
    OP_JUDGE,
    OP_DECIDE,
    OP_UP,
    OP_FILL,
    OP_DN,
    OP_RESULT
  } skt_op_t;

  typedef struct packed {
    skt_op_t op;
  } skt_cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic              done;       // search finished
    logic              len_zero;   // live search range is empty
    logic              hit;        // search matched
    logic [MODE_W-1:0] mode;       // mode of the request in work
    logic              full;       // table holds capacity entries
    logic              pos_at_end; // insertion index equals count
    logic              dn_last;    // deleted entry is the last one
    logic              up_last;    // upward move reached the insertion index
    logic              dn_end;     // downward move reached the last entry
  } skt_stat_t;

endpackage

FILE: sv/skt_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// depends on nothing

module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/skt_ctrl.sv
// controller state machine of the sorted key table
// depends on skt_pkg; drives the datapath through skt_cmd_t

module skt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_JUDGE,
    S_DECIDE,
    S_UP,
    S_FILL,
    S_DN,
    S_RESULT
  } state_t;

  state_t state, state_next;

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = skt_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = skt_pkg::OP_LOAD;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.op     = skt_pkg::OP_PROBE;
          state_next = stat.len_zero ? S_SEARCH : S_JUDGE;
        end
      end
      S_JUDGE: begin
        cmd.op     = skt_pkg::OP_JUDGE;
        state_next = S_SEARCH;
      end
      S_DECIDE: begin
        cmd.op     = skt_pkg::OP_DECIDE;
        state_next = S_RESULT;
        if (stat.mode == skt_pkg::MODE_SET && !stat.hit && !stat.full && !stat.pos_at_end) begin
          state_next = S_UP;
        end
        if (stat.mode == skt_pkg::MODE_DEL && stat.hit && !stat.dn_last) begin
          state_next = S_DN;
        end
      end
      S_UP: begin
        cmd.op = skt_pkg::OP_UP;
        if (stat.up_last) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.op     = skt_pkg::OP_FILL;
        state_next = S_RESULT;
      end
      S_DN: begin
        cmd.op = skt_pkg::OP_DN;
        if (stat.dn_end) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd.op     = skt_pkg::OP_RESULT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: sv/skt_dp.sv
// datapath of the sorted key table: request, search range, count, entry ram
// depends on skt_pkg and skt_ram; obeys skt_cmd_t from the controller

module skt_dp #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int EW      = skt_pkg::KEY_W + skt_pkg::VAL_W
) (
  input  logic               clk,
  input  logic               rst,
  input  skt_pkg::skt_req_t  request,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  input  skt_pkg::skt_cmd_t  cmd,
  output skt_pkg::skt_stat_t stat,
  output logic               done,
  output skt_pkg::skt_res_t  result
);

  skt_pkg::skt_req_t         req;
  logic                      signed_keys;
  logic [CW-1:0]             count;
  logic [CW-1:0]             base;
  logic [CW-1:0]             len;
  logic [CW-1:0]             pos;
  logic [AW-1:0]             idx;
  logic                      hit;
  logic                      srch_done;
  logic [skt_pkg::VAL_W-1:0] fval;
  logic [skt_pkg::STATUS_W-1:0] res_status;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [CW-1:0]             mid;
  logic [CW-1:0]             right;
  logic [skt_pkg::KEY_W-1:0] key_a;
  logic [skt_pkg::KEY_W-1:0] key_b;
  logic                      key_lt;
  logic                      key_gt;
  logic                      full;
  logic [CW:0]               pos_inc;
  logic [CW:0]               idx_inc;

  // probe split and ordered compare against the entry just read
  assign mid    = len >> 1;
  assign right  = len - mid - CW'(1);
  assign key_a  = req.key ^ {signed_keys, {(skt_pkg::KEY_W-1){1'b0}}};
  assign key_b  = ram_rdata[EW-1 -: skt_pkg::KEY_W] ^ {signed_keys, {(skt_pkg::KEY_W-1){1'b0}}};
  assign key_lt = key_a < key_b;
  assign key_gt = key_a > key_b;
  assign full   = (count == CW'(CAPACITY));
  assign pos_inc = {1'b0, pos} + (CW+1)'(1);
  assign idx_inc = (CW+1)'(idx) + (CW+1)'(1);

  // status toward the controller
  assign stat.done       = srch_done;
  assign stat.len_zero   = (len == '0);
  assign stat.hit        = hit;
  assign stat.mode       = req.mode;
  assign stat.full       = full;
  assign stat.pos_at_end = (pos == count);
  assign stat.dn_last    = (pos_inc >= {1'b0, count});
  assign stat.up_last    = (CW'(idx) == pos);
  assign stat.dn_end     = (idx_inc == {1'b0, count});

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(pos);
    ram_wdata = {req.key, req.value};
    ram_re    = 1'b0;
    ram_raddr = AW'(base + mid);
    case (cmd.op)
      skt_pkg::OP_PROBE: begin
        ram_re = (len != '0);
      end
      skt_pkg::OP_DECIDE: begin
        if (req.mode == skt_pkg::MODE_SET && !full && (hit || pos == count)) begin
          ram_we = 1'b0 | hit | (pos == count);
        end
        if (req.mode == skt_pkg::MODE_SET && hit) begin
          ram_we = 1'b1;
        end
        if (req.mode == skt_pkg::MODE_SET && !hit && !full && pos != count) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(count - CW'(1));
        end
        if (req.mode == skt_pkg::MODE_DEL && hit && !stat.dn_last) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(pos_inc);
        end
      end
      skt_pkg::OP_UP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_inc);
        ram_wdata = ram_rdata;
        ram_re    = (CW'(idx) != pos);
        ram_raddr = idx - AW'(1);
      end
      skt_pkg::OP_FILL: begin
        ram_we = 1'b1;
      end
      skt_pkg::OP_DN: begin
        ram_we    = 1'b1;
        ram_waddr = idx - AW'(1);
        ram_wdata = ram_rdata;
        ram_re    = !stat.dn_end;
        ram_raddr = AW'(idx_inc);
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_keys <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      signed_keys <= cfg_data;
    end
  end

  // entry count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (cmd.op == skt_pkg::OP_RESULT);
      case (cmd.op)
        skt_pkg::OP_DECIDE: begin
          if (req.mode == skt_pkg::MODE_SET && !hit && !full && pos == count) begin
            count <= count + CW'(1);
          end
          if (req.mode == skt_pkg::MODE_DEL && hit && stat.dn_last) begin
            count <= count - CW'(1);
          end
        end
        skt_pkg::OP_FILL: begin
          count <= count + CW'(1);
        end
        skt_pkg::OP_DN: begin
          if (stat.dn_end) begin
            count <= count - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request, search range and result payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      skt_pkg::OP_LOAD: begin
        req       <= request;
        base      <= '0;
        len       <= (request.mode == skt_pkg::MODE_SET || request.mode == skt_pkg::MODE_GET ||
                      request.mode == skt_pkg::MODE_DEL) ? count : '0;
        srch_done <= !(request.mode == skt_pkg::MODE_SET || request.mode == skt_pkg::MODE_GET ||
                       request.mode == skt_pkg::MODE_DEL);
        pos       <= '0;
        hit       <= 1'b0;
        fval      <= '0;
      end
      skt_pkg::OP_PROBE: begin
        if (len == '0) begin
          pos       <= base;
          srch_done <= 1'b1;
        end
      end
      skt_pkg::OP_JUDGE: begin
        if (key_lt) begin
          if (mid == '0) begin
            pos       <= base;
            srch_done <= 1'b1;
          end else begin
            len <= mid;
          end
        end else if (key_gt) begin
          if (right == '0) begin
            pos       <= base + len;
            srch_done <= 1'b1;
          end else begin
            base <= base + mid + CW'(1);
            len  <= right;
          end
        end else begin
          pos       <= base + mid;
          hit       <= 1'b1;
          srch_done <= 1'b1;
          fval      <= ram_rdata[skt_pkg::VAL_W-1:0];
        end
      end
      skt_pkg::OP_DECIDE: begin
        res_status <= skt_pkg::ST_NOT_FOUND;
        case (req.mode)
          skt_pkg::MODE_SET: begin
            if (hit) begin
              res_status <= skt_pkg::ST_REPLACED;
            end else if (full) begin
              res_status <= skt_pkg::ST_FULL;
            end else begin
              res_status <= skt_pkg::ST_INSERTED;
            end
            idx <= AW'(count - CW'(1));
          end
          skt_pkg::MODE_GET: begin
            if (hit) begin
              res_status <= skt_pkg::ST_FOUND;
            end
          end
          skt_pkg::MODE_DEL: begin
            if (hit) begin
              res_status <= skt_pkg::ST_DELETED;
            end
            idx <= AW'(pos_inc);
          end
          default: begin
          end
        endcase
      end
      skt_pkg::OP_UP: begin
        if (CW'(idx) != pos) begin
          idx <= idx - AW'(1);
        end
      end
      skt_pkg::OP_DN: begin
        if (!stat.dn_end) begin
          idx <= AW'(idx_inc);
        end
      end
      skt_pkg::OP_RESULT: begin
        result.status      <= res_status;
        result.found_value <= (res_status == skt_pkg::ST_FOUND) ? fval : '0;
        result.position    <= skt_pkg::POS_W'(pos);
        result.entry_count <= skt_pkg::POS_W'(count);
      end
      default: begin
      end
    endcase
  end

  // key and value entries, one ram word each
  skt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: sv/sorted_key_table_top.sv
// sorted key table: ascending key/value entries in one ram, binary search lookup
// each request runs a binary search of at most clog2(CAPACITY)+1 ram probes; set and delete then
// move the later entries one per cycle to open a gap at the insertion index or close the deleted one
// one request at a time: busy drops as done rises, the next start is taken at the done beat
// results cannot be stalled; synchronous reset empties the table and selects unsigned keys
module sorted_key_table_top #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  skt_pkg::skt_req_t request,
  output logic              done,
  output skt_pkg::skt_res_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  skt_pkg::skt_cmd_t  cmd;
  skt_pkg::skt_stat_t stat;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // controller
  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  skt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule
